/* rtl/fscp_pkg.sv */
package fscp_pkg;

    // stage slots and slot index width
    localparam int STAGES = 8;
    localparam int SLOT_W = (STAGES > 1) ? $clog2(STAGES) : 1;

    // field widths
    localparam int MODE_W = 3;
    localparam int SIDX_W = 4;
    localparam int WORD_W = 32;
    localparam int PSTG_W = 3;

    // stream word widths, rounded up to whole bytes
    localparam int IN_BITS   = MODE_W + SIDX_W + 2 * WORD_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 6 * WORD_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // event modes
    localparam logic [MODE_W-1:0] MODE_FRAME_BEGIN = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STAGE_BEGIN = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STAGE_END   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POLL_BEGIN  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POLL_END    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_BLOCKED_ADD = 3'd5;
    localparam logic [MODE_W-1:0] MODE_FRAME_END   = 3'd6;

    // configuration register indexes
    localparam logic CFG_CLOCK_RATE = 1'b0;
    localparam logic CFG_POLL_STAGE = 1'b1;

    // configuration reset values
    localparam logic [WORD_W-1:0] CLOCK_RATE_RST = 32'd100000000;
    localparam logic [PSTG_W-1:0] POLL_STAGE_RST = 3'd7;

    // latency conversion: length * NS_PER_SEC fits in PROD_W bits
    localparam int NS_W = 30;
    localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;
    localparam int PROD_W = WORD_W + NS_W;
    localparam int MUL_STEPS = WORD_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W = $clog2(DIV_STEPS);

endpackage

/* rtl/frame_stage_cycle_profiler.sv */
// channel   | dir | handshake               | word contents (low bit up)
// ----------+-----+-------------------------+--------------------------------------------
// event in  | in  | s_axis_tvalid/tready    | mode, stage_index, add_amount, timestamp
// result    | out | m_axis_tvalid/tready    | stage_value, active_total, polling_total,
//           |     |                         | blocked_total, wall_value, latency_ns, ignored
// config    | in  | i_cfg_we                | i_cfg_index selects the register, i_cfg_data
//
// one event at a time: most events go from idle through exec to done, where the result is
// loaded into the output register; a stage end in range also passes an accumulate state
// a frame end passes through 32 steps of the bit-serial multiplier by 1e9 and
// 62 steps of the restoring divider by clock_rate_hz, one bit per cycle each
// synchronous active-low reset clears all counters and slots and reloads config defaults
// a finished result waits in the output register; the next event is taken meanwhile
// and its result waits until the output register is free
module frame_stage_cycle_profiler import fscp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // mode, stage_index, add_amount, timestamp, zero fill
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // stage_value, active_total, polling_total, blocked_total, wall_value,
    // latency_ns, ignored, zero fill
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_index,
    input  logic [WORD_W-1:0]       i_cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]             r_state;
    logic [WORD_W-1:0]      r_clock_rate;
    logic [PSTG_W-1:0]      r_poll_stage;

    logic [WORD_W-1:0]      r_slots [STAGES];
    logic [WORD_W-1:0]      r_active;
    logic [WORD_W-1:0]      r_polling;
    logic [WORD_W-1:0]      r_blocked;
    logic [WORD_W-1:0]      r_wall;
    logic [WORD_W-1:0]      r_latency;

    // latched event
    logic [MODE_W-1:0]      r_mode;
    logic [SIDX_W-1:0]      r_addr;
    logic                   r_in_range;
    logic [WORD_W-1:0]      r_amount;
    logic [WORD_W-1:0]      r_ts;

    // serial multiply and divide
    logic [WORD_W-1:0]      r_mcand;
    logic [PROD_W-1:0]      r_prod;
    logic [WORD_W-1:0]      r_rem;
    logic [WORD_W-1:0]      r_quo;
    logic [CNT_W-1:0]       r_cnt;

    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;

    logic [MODE_W-1:0]      in_mode;
    logic [SIDX_W-1:0]      in_sidx;
    logic [SIDX_W-1:0]      in_addr;
    logic                   is_poll;
    logic [SLOT_W-1:0]      slot;
    logic [WORD_W-1:0]      slot_diff;
    logic [WORD_W-1:0]      wall_diff;
    logic [PROD_W-1:0]      n_prod;
    logic [WORD_W:0]        trial;
    logic [WORD_W:0]        trial_sub;
    logic                   q_bit;
    logic                   out_free;
    logic [WORD_W-1:0]      stage_val;
    logic                   ign;

    // input field decode and slot address
    assign in_mode = s_axis_tdata[MODE_W-1:0];
    assign in_sidx = s_axis_tdata[MODE_W +: SIDX_W];
    assign is_poll = (in_mode == MODE_POLL_BEGIN) || (in_mode == MODE_POLL_END);
    assign in_addr = is_poll ? SIDX_W'(r_poll_stage) : in_sidx;

    assign slot      = r_addr[SLOT_W-1:0];
    assign slot_diff = r_ts - r_slots[slot];
    assign wall_diff = r_ts - r_wall;

    // one multiplier bit per cycle, msb first
    assign n_prod = {r_prod[PROD_W-2:0], 1'b0}
                  + (r_mcand[WORD_W-1] ? PROD_W'(NS_PER_SEC) : PROD_W'(0));

    // one quotient bit per cycle; a zero divisor yields all ones
    assign trial     = {r_rem, r_prod[PROD_W-1]};
    assign trial_sub = trial - {1'b0, r_clock_rate};
    assign q_bit     = (trial >= {1'b0, r_clock_rate});

    // result assembly
    assign ign = !r_in_range && ((r_mode == MODE_STAGE_BEGIN) || (r_mode == MODE_STAGE_END)
               || (r_mode == MODE_POLL_BEGIN) || (r_mode == MODE_POLL_END));
    assign stage_val = r_in_range ? r_slots[slot] : '0;
    assign out_free  = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // control, state and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_clock_rate <= CLOCK_RATE_RST;
            r_poll_stage <= POLL_STAGE_RST;
            for (int i = 0; i < STAGES; i++) begin
                r_slots[i] <= '0;
            end
            r_active    <= '0;
            r_polling   <= '0;
            r_blocked   <= '0;
            r_wall      <= '0;
            r_latency   <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CLOCK_RATE: r_clock_rate <= i_cfg_data;
                    CFG_POLL_STAGE: r_poll_stage <= i_cfg_data[PSTG_W-1:0];
                    default: ;
                endcase
            end

            // result taken; the done state reloads the register itself
            if (r_out_valid && m_axis_tready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_mode     <= in_mode;
                        r_addr     <= in_addr;
                        r_in_range <= (32'(in_addr) < STAGES);
                        r_amount   <= s_axis_tdata[MODE_W + SIDX_W +: WORD_W];
                        r_ts       <= s_axis_tdata[MODE_W + SIDX_W + WORD_W +: WORD_W];
                        r_state    <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    unique case (r_mode)
                        MODE_FRAME_BEGIN: begin
                            for (int i = 0; i < STAGES; i++) begin
                                r_slots[i] <= '0;
                            end
                            r_active  <= '0;
                            r_polling <= '0;
                            r_blocked <= '0;
                            r_wall    <= r_ts;
                            r_latency <= '0;
                            r_state   <= ST_DONE;
                        end
                        MODE_STAGE_BEGIN, MODE_POLL_BEGIN: begin
                            if (r_in_range) begin
                                r_slots[slot] <= r_ts;
                            end
                            r_state <= ST_DONE;
                        end
                        MODE_STAGE_END: begin
                            if (r_in_range) begin
                                r_slots[slot] <= slot_diff;
                                r_state       <= ST_ACC;
                            end else begin
                                r_state <= ST_DONE;
                            end
                        end
                        MODE_POLL_END: begin
                            if (r_in_range) begin
                                r_slots[slot] <= slot_diff;
                                r_polling     <= slot_diff;
                            end
                            r_state <= ST_DONE;
                        end
                        MODE_BLOCKED_ADD: begin
                            r_blocked <= r_blocked + r_amount;
                            r_state   <= ST_DONE;
                        end
                        MODE_FRAME_END: begin
                            r_wall  <= wall_diff;
                            r_mcand <= wall_diff;
                            r_prod  <= '0;
                            r_cnt   <= '0;
                            r_state <= ST_MUL;
                        end
                        default: r_state <= ST_DONE;
                    endcase
                end
                ST_ACC: begin
                    r_active <= r_active + r_slots[slot];
                    r_state  <= ST_DONE;
                end
                ST_MUL: begin
                    r_prod  <= n_prod;
                    r_mcand <= {r_mcand[WORD_W-2:0], 1'b0};
                    if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_state <= ST_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DIV: begin
                    r_prod <= {r_prod[PROD_W-2:0], 1'b0};
                    r_rem  <= q_bit ? trial_sub[WORD_W-1:0] : trial[WORD_W-1:0];
                    r_quo  <= {r_quo[WORD_W-2:0], q_bit};
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_latency <= {r_quo[WORD_W-2:0], q_bit};
                        r_state   <= ST_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= OUT_DATA_W'({ign, r_latency, r_wall, r_blocked,
                                                    r_polling, r_active, stage_val});
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

/* rtl/fscp_checker.sv */
module fscp_checker import fscp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_DATA_W-1:0]   m_axis_tdata
);

    // no result word straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

    // a held result keeps its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // one event at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("event taken while another is in work");

    // a dropped event reports an empty stage value
    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[6*WORD_W] |-> m_axis_tdata[WORD_W-1:0] == '0)
        else $error("ignored event with nonzero stage value");

endmodule

bind frame_stage_cycle_profiler fscp_checker u_fscp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
